>>> hw/rtl/bhst_pkg.sv
// Shared types, constants and arithmetic steps for the bezier handle seed toggle.
package bhst_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 16;                  // coordinate width
    localparam int DW        = CW + 1;              // coordinate difference width
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int SQ_W      = 36;                  // radicand width
    localparam int ROOT_W    = 34;                  // root width, Q.FRAC_BITS
    localparam int REM_W     = ROOT_W + 3;
    localparam int DEN_W     = ROOT_W + 2;          // 3 * tangent length
    localparam int QUO_W     = 32;                  // scale width, Q.FRAC_BITS
    localparam int NUM_W     = ROOT_W + FRAC_BITS;  // dividend width
    localparam int PROD_W    = CW + QUO_W;
    localparam int SQ_ITERS  = 2;
    localparam int SQ_STG    = (SQ_W / 2 + FRAC_BITS) / SQ_ITERS;
    localparam int DV_ITERS  = 2;
    localparam int DV_STG    = QUO_W / DV_ITERS;
    localparam int NLANE     = 3;                   // tangent, first segment, second segment

    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(1024);
    // 0.001 in Q.FRAC_BITS, rounded
    localparam logic [ROOT_W-1:0] TL_MIN  = ROOT_W'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [CW-1:0]     HMAX    = CW'(32767);

    typedef struct packed {
        logic [SQ_W-1:0]   rad;
        logic [ROOT_W-1:0] root;
        logic [REM_W-1:0]  rem;
    } sqrt_t;

    typedef struct packed {
        logic [QUO_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } div_t;

    typedef struct packed {
        logic                 chg;
        logic                 kill;
        logic                 two;
        logic signed [DW-1:0] tx;
        logic signed [DW-1:0] ty;
        logic                 fail;
        logic                 s2z;
    } side_t;

    function automatic sqrt_t sqrt_iter(sqrt_t a);
        sqrt_t            r;
        logic [REM_W-1:0] rm;
        logic [REM_W-1:0] trial;
        rm     = {a.rem[REM_W-3:0], a.rad[SQ_W-1 -: 2]};
        trial  = {1'b0, a.root, 2'b01};
        r.rad  = {a.rad[SQ_W-3:0], 2'b00};
        if (rm >= trial) begin
            r.rem  = rm - trial;
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = rm;
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic div_t div_iter(div_t a);
        div_t             r;
        logic [DEN_W:0]   r2;
        logic [DEN_W:0]   d;
        r2    = {a.rem, a.num[QUO_W-1]};
        d     = r2 - {1'b0, a.den};
        r.num = {a.num[QUO_W-2:0], 1'b0};
        r.den = a.den;
        if (r2 >= {1'b0, a.den}) begin
            r.rem = d[DEN_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = r2[DEN_W-1:0];
            r.quo = {a.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/bhst_sqrt_stage.sv
// One pipeline stage of the bit-pair square root (two result bits per stage).
module bhst_sqrt_stage (
    input  logic            aclk,
    input  logic            en,
    input  bhst_pkg::sqrt_t d_in,
    output bhst_pkg::sqrt_t d_out
);
    import bhst_pkg::*;

    sqrt_t st_next;
    sqrt_t st_reg;

    always_comb begin
        st_next = d_in;
        for (int i = 0; i < SQ_ITERS; i++) begin
            st_next = sqrt_iter(st_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

>>> hw/rtl/bhst_div_stage.sv
// One pipeline stage of the restoring divider (two quotient bits per stage).
module bhst_div_stage (
    input  logic           aclk,
    input  logic           en,
    input  bhst_pkg::div_t d_in,
    output bhst_pkg::div_t d_out
);
    import bhst_pkg::*;

    div_t st_next;
    div_t st_reg;

    always_comb begin
        st_next = d_in;
        for (int i = 0; i < DV_ITERS; i++) begin
            st_next = div_iter(st_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign d_out = st_reg;

endmodule

>>> hw/rtl/bezier_handle_seed_toggle_core.sv
// Top level: bezier handle seed toggle pipeline.
// Throughput: one item per cycle; the whole pipeline stalls together while
// the output register holds a result that is not taken.
// Depth is set by the 34-bit square root (17 stages) and the 32-bit divider (16 stages).
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
module bezier_handle_seed_toggle_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [bhst_pkg::CW-1:0] s_cur_x,
    input  logic signed [bhst_pkg::CW-1:0] s_cur_y,
    input  logic signed [bhst_pkg::CW-1:0] s_before_x,
    input  logic signed [bhst_pkg::CW-1:0] s_before_y,
    input  logic signed [bhst_pkg::CW-1:0] s_after_x,
    input  logic signed [bhst_pkg::CW-1:0] s_after_y,
    input  logic [bhst_pkg::IDX_W-1:0]     s_pos_index,
    input  logic [bhst_pkg::CNT_W-1:0]     s_pos_count,
    input  logic                          s_is_closed,
    input  logic                          s_curve_on,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_changed,
    output logic                          m_new_curve_on,
    output logic                          m_new_linked,
    output logic signed [bhst_pkg::CW-1:0] m_in_dx,
    output logic signed [bhst_pkg::CW-1:0] m_in_dy,
    output logic signed [bhst_pkg::CW-1:0] m_out_dx,
    output logic signed [bhst_pkg::CW-1:0] m_out_dy
);
    import bhst_pkg::*;

    logic en;

    // front stage
    logic                 bad, single, prv_ok, nxt_ok, two;
    logic [CNT_W-1:0]     idx_ext;
    logic signed [DW-1:0] ac_x, ac_y, cb_x, cb_y, ab_x, ab_y;
    logic signed [DW-1:0] a_x_next [NLANE];
    logic signed [DW-1:0] a_y_next [NLANE];
    logic signed [DW-1:0] a_x_reg  [NLANE];
    logic signed [DW-1:0] a_y_reg  [NLANE];
    side_t                a_side_next, a_side_reg;
    logic                 a_valid_reg;

    // squares
    logic signed [2*DW-1:0] px [NLANE];
    logic signed [2*DW-1:0] py [NLANE];
    logic [SQ_W-1:0]        b_sq_next [NLANE];
    logic [SQ_W-1:0]        b_sq_reg  [NLANE];
    side_t                  b_side_reg;
    logic                   b_valid_reg;

    // square root chain
    sqrt_t sq_st [SQ_STG+1][NLANE];
    side_t sq_side_reg  [SQ_STG];
    logic  sq_valid_reg [SQ_STG];

    // divider chain
    logic [ROOT_W-1:0] tl, s1, s2;
    logic [DEN_W-1:0]  den;
    logic [NUM_W-1:0]  n1, n2;
    side_t             dv_side_in;
    div_t              dv_st [DV_STG+1][2];
    side_t             dv_side_reg  [DV_STG];
    logic              dv_valid_reg [DV_STG];

    // multiply stage
    side_t                t_side;
    logic [DW-1:0]        neg_x, neg_y;
    logic [CW-1:0]        mag_x, mag_y;
    logic [PROD_W-1:0]    c_px_next [2];
    logic [PROD_W-1:0]    c_py_next [2];
    logic [PROD_W-1:0]    c_px_reg  [2];
    logic [PROD_W-1:0]    c_py_reg  [2];
    side_t                c_side_reg;
    logic                 c_valid_reg;

    // round and output
    logic signed [CW-1:0] h1x, h1y, h2x, h2y;
    logic                 seed_ok;
    logic                 m_valid_reg;
    logic                 m_changed_next, m_changed_reg;
    logic                 m_curve_next, m_curve_reg;
    logic signed [CW-1:0] m_in_dx_next, m_in_dy_next, m_out_dx_next, m_out_dy_next;
    logic signed [CW-1:0] m_in_dx_reg, m_in_dy_reg, m_out_dx_reg, m_out_dy_reg;

    function automatic logic signed [CW-1:0] round_sat(logic [PROD_W-1:0] p, logic neg);
        logic [PROD_W-1:0]         s;
        logic [PROD_W-FRAC_BITS-1:0] v;
        logic [CW-1:0]             m;
        s = p + PROD_W'(1 << (FRAC_BITS - 1));
        v = s[PROD_W-1:FRAC_BITS];
        m = (v > (PROD_W-FRAC_BITS)'(HMAX)) ? HMAX : v[CW-1:0];
        return neg ? -$signed(m) : $signed(m);
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // ---------------- front ----------------
    always_comb begin
        idx_ext  = {1'b0, s_pos_index};
        bad      = (s_pos_count == '0) || (s_pos_count > CNT_MAX) || (idx_ext >= s_pos_count);
        single   = (s_pos_count == CNT_W'(1));
        prv_ok   = (s_is_closed || (s_pos_index != '0)) && !single;
        nxt_ok   = (s_is_closed || ((idx_ext + CNT_W'(1)) < s_pos_count)) && !single;
        two      = prv_ok && nxt_ok;
        ac_x = {s_after_x[CW-1], s_after_x} - {s_cur_x[CW-1], s_cur_x};
        ac_y = {s_after_y[CW-1], s_after_y} - {s_cur_y[CW-1], s_cur_y};
        cb_x = {s_cur_x[CW-1], s_cur_x} - {s_before_x[CW-1], s_before_x};
        cb_y = {s_cur_y[CW-1], s_cur_y} - {s_before_y[CW-1], s_before_y};
        ab_x = {s_after_x[CW-1], s_after_x} - {s_before_x[CW-1], s_before_x};
        ab_y = {s_after_y[CW-1], s_after_y} - {s_before_y[CW-1], s_before_y};
        a_x_next[0] = two ? ab_x : (nxt_ok ? ac_x : cb_x);
        a_y_next[0] = two ? ab_y : (nxt_ok ? ac_y : cb_y);
        // single neighbour: the segment is the tangent
        a_x_next[1] = two ? cb_x : a_x_next[0];
        a_y_next[1] = two ? cb_y : a_y_next[0];
        a_x_next[2] = ac_x;
        a_y_next[2] = ac_y;
        a_side_next.chg  = !bad;
        a_side_next.kill = bad || s_curve_on || !(prv_ok || nxt_ok);
        a_side_next.two  = two;
        a_side_next.tx   = a_x_next[0];
        a_side_next.ty   = a_y_next[0];
        a_side_next.fail = 1'b0;
        a_side_next.s2z  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_side_reg <= a_side_next;
            for (int l = 0; l < NLANE; l++) begin
                a_x_reg[l] <= a_x_next[l];
                a_y_reg[l] <= a_y_next[l];
            end
        end
    end

    // ---------------- squares ----------------
    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            px[l]        = a_x_reg[l] * a_x_reg[l];
            py[l]        = a_y_reg[l] * a_y_reg[l];
            b_sq_next[l] = SQ_W'($unsigned(px[l])) + SQ_W'($unsigned(py[l]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_side_reg <= a_side_reg;
            for (int l = 0; l < NLANE; l++) begin
                b_sq_reg[l] <= b_sq_next[l];
            end
        end
    end

    // ---------------- square roots ----------------
    for (genvar l = 0; l < NLANE; l++) begin : g_sq_lane
        assign sq_st[0][l] = '{rad: b_sq_reg[l], root: '0, rem: '0};
        for (genvar g = 0; g < SQ_STG; g++) begin : g_sq_stg
            bhst_sqrt_stage u_sqrt (
                .aclk  (aclk),
                .en    (en),
                .d_in  (sq_st[g][l]),
                .d_out (sq_st[g+1][l])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= b_side_reg;
            for (int i = 1; i < SQ_STG; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // ---------------- divider ----------------
    always_comb begin
        tl  = sq_st[SQ_STG][0].root;
        s1  = sq_st[SQ_STG][1].root;
        s2  = sq_st[SQ_STG][2].root;
        den = {2'b00, tl} + {1'b0, tl, 1'b0};
        n1  = {s1, {FRAC_BITS{1'b0}}};
        n2  = {s2, {FRAC_BITS{1'b0}}};
        dv_side_in      = sq_side_reg[SQ_STG-1];
        dv_side_in.fail = (tl < TL_MIN) || (s1 == '0);
        dv_side_in.s2z  = (s2 == '0);
    end

    // quotient fits QUO_W bits, so the bits above start as the remainder
    assign dv_st[0][0] = '{num: n1[QUO_W-1:0], rem: DEN_W'(n1 >> QUO_W), den: den, quo: '0};
    assign dv_st[0][1] = '{num: n2[QUO_W-1:0], rem: DEN_W'(n2 >> QUO_W), den: den, quo: '0};

    for (genvar l = 0; l < 2; l++) begin : g_dv_lane
        for (genvar g = 0; g < DV_STG; g++) begin : g_dv_stg
            bhst_div_stage u_div (
                .aclk  (aclk),
                .en    (en),
                .d_in  (dv_st[g][l]),
                .d_out (dv_st[g+1][l])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_side_reg[0] <= dv_side_in;
            for (int i = 1; i < DV_STG; i++) begin
                dv_side_reg[i] <= dv_side_reg[i-1];
            end
        end
    end

    // ---------------- multiply ----------------
    always_comb begin
        t_side = dv_side_reg[DV_STG-1];
        neg_x  = -t_side.tx;
        neg_y  = -t_side.ty;
        mag_x  = t_side.tx[DW-1] ? neg_x[CW-1:0] : t_side.tx[CW-1:0];
        mag_y  = t_side.ty[DW-1] ? neg_y[CW-1:0] : t_side.ty[CW-1:0];
        for (int l = 0; l < 2; l++) begin
            c_px_next[l] = PROD_W'(mag_x) * PROD_W'(dv_st[DV_STG][l].quo);
            c_py_next[l] = PROD_W'(mag_y) * PROD_W'(dv_st[DV_STG][l].quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_side_reg <= t_side;
            for (int l = 0; l < 2; l++) begin
                c_px_reg[l] <= c_px_next[l];
                c_py_reg[l] <= c_py_next[l];
            end
        end
    end

    // ---------------- round and select ----------------
    always_comb begin
        h1x     = round_sat(c_px_reg[0], c_side_reg.tx[DW-1]);
        h1y     = round_sat(c_py_reg[0], c_side_reg.ty[DW-1]);
        h2x     = round_sat(c_px_reg[1], c_side_reg.tx[DW-1]);
        h2y     = round_sat(c_py_reg[1], c_side_reg.ty[DW-1]);
        seed_ok = !c_side_reg.kill && !c_side_reg.fail && ((h1x != '0) || (h1y != '0));
        m_changed_next = c_side_reg.chg;
        m_curve_next   = seed_ok;
        m_in_dx_next   = '0;
        m_in_dy_next   = '0;
        m_out_dx_next  = '0;
        m_out_dy_next  = '0;
        if (seed_ok) begin
            m_in_dx_next = -h1x;
            m_in_dy_next = -h1y;
            // a zero next segment keeps the handle from the previous one
            if (c_side_reg.two && !c_side_reg.s2z) begin
                m_out_dx_next = h2x;
                m_out_dy_next = h2y;
            end else begin
                m_out_dx_next = h1x;
                m_out_dy_next = h1y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_changed_reg <= m_changed_next;
            m_curve_reg   <= m_curve_next;
            m_in_dx_reg   <= m_in_dx_next;
            m_in_dy_reg   <= m_in_dy_next;
            m_out_dx_reg  <= m_out_dx_next;
            m_out_dy_reg  <= m_out_dy_next;
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < SQ_STG; i++) begin
                sq_valid_reg[i] <= 1'b0;
            end
            for (int i = 0; i < DV_STG; i++) begin
                dv_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            a_valid_reg     <= s_valid;
            b_valid_reg     <= a_valid_reg;
            sq_valid_reg[0] <= b_valid_reg;
            for (int i = 1; i < SQ_STG; i++) begin
                sq_valid_reg[i] <= sq_valid_reg[i-1];
            end
            dv_valid_reg[0] <= sq_valid_reg[SQ_STG-1];
            for (int i = 1; i < DV_STG; i++) begin
                dv_valid_reg[i] <= dv_valid_reg[i-1];
            end
            c_valid_reg <= dv_valid_reg[DV_STG-1];
            m_valid_reg <= c_valid_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_changed      = m_changed_reg;
    assign m_new_curve_on = m_curve_reg;
    assign m_new_linked   = m_curve_reg;
    assign m_in_dx        = m_in_dx_reg;
    assign m_in_dy        = m_in_dy_reg;
    assign m_out_dx       = m_out_dx_reg;
    assign m_out_dy       = m_out_dy_reg;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output valid after reset");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_changed |-> !m_new_curve_on && (m_in_dx == '0) && (m_in_dy == '0)
            && (m_out_dx == '0) && (m_out_dy == '0))
        else $error("invalid point item carries data");
    a_curve_has_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_new_curve_on |-> m_changed && ((m_in_dx != '0) || (m_in_dy != '0)))
        else $error("curve point without incoming handle");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg && m_valid && !m_ready |=> c_valid_reg)
        else $error("pipeline item dropped during stall");
`endif

endmodule
